@@ rtl/metropolis_clock_spin_update_top_macros.svh @@
// Assertion macros for the checker file of the spin update block.
// No dependencies; each macro expects signals clk and rst_n in scope.
`ifndef METROPOLIS_CLOCK_SPIN_UPDATE_TOP_MACROS_SVH
`define METROPOLIS_CLOCK_SPIN_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spin update check failed");

// Next-cycle implication, disabled during reset.
`define MCSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spin update check failed");

`endif

@@ rtl/mcsu_pkg.sv @@
// Package of the spin update block: controller states, command and status
// structs, fixed-point constants and the cosine coupling table. No dependencies.
package mcsu_pkg;

    // Fixed-point constants of the exp approximation.
    localparam logic [15:0] LOG2E_Q15 = 16'd47275;
    localparam logic [16:0] HORNER_K0 = 17'd3638;
    localparam logic [16:0] HORNER_K1 = 17'd15744;
    localparam logic [16:0] HORNER_K2 = 17'd45426;
    localparam logic [16:0] HORNER_K3 = 17'd65536;
    localparam logic [16:0] HORNER_C0 = 17'd630;
    localparam logic [14:0] BETA_RESET = 15'd4096;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RC,
        ST_RD_OLD,
        ST_RD_N0,
        ST_RD_N1,
        ST_RD_N2,
        ST_RD_N3,
        ST_RD_LAST,
        ST_EVAL,
        ST_MUL_P,
        ST_MUL_Y,
        ST_H0,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_THR,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        RS_SITE,
        RS_UP,
        RS_DOWN,
        RS_LEFT,
        RS_RIGHT
    } ram_sel_t;

    typedef enum logic [1:0] {
        HS_STEP0,
        HS_STEP1,
        HS_STEP2,
        HS_STEP3
    } hstep_t;

    typedef struct packed {
        logic     clear;
        logic     load;
        logic     map_mod;
        logic     map_rc;
        ram_sel_t ram_sel;
        logic     cap_old;
        logic     acc_nb;
        logic     mul_p;
        logic     mul_y;
        logic     horner;
        hstep_t   hstep;
        logic     thr;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_exp;
    } status_t;

    // cos(2*pi*d/q) in signed Q2.12 for q states.
    function automatic logic signed [13:0] cos_q12(input int q, input logic [3:0] d);
        logic signed [13:0] v;
        v = 14'sd0;
        unique case (q)
            2: unique case (d[2:0])
                3'd0: v = 14'sd4096;
                3'd1: v = -14'sd4096;
                default: v = 14'sd0;
            endcase
            3: unique case (d[2:0])
                3'd0: v = 14'sd4096;
                3'd1, 3'd2: v = -14'sd2048;
                default: v = 14'sd0;
            endcase
            4: unique case (d[2:0])
                3'd0: v = 14'sd4096;
                3'd2: v = -14'sd4096;
                default: v = 14'sd0;
            endcase
            5: unique case (d[2:0])
                3'd0: v = 14'sd4096;
                3'd1, 3'd4: v = 14'sd1266;
                3'd2, 3'd3: v = -14'sd3314;
                default: v = 14'sd0;
            endcase
            6: unique case (d[2:0])
                3'd0: v = 14'sd4096;
                3'd1, 3'd5: v = 14'sd2048;
                3'd2, 3'd4: v = -14'sd2048;
                3'd3: v = -14'sd4096;
                default: v = 14'sd0;
            endcase
            7: unique case (d[2:0])
                3'd0: v = 14'sd4096;
                3'd1, 3'd6: v = 14'sd2554;
                3'd2, 3'd5: v = -14'sd911;
                default: v = -14'sd3690;
            endcase
            default: unique case (d[2:0])
                3'd0: v = 14'sd4096;
                3'd1, 3'd7: v = 14'sd2896;
                3'd3, 3'd5: v = -14'sd2896;
                3'd4: v = -14'sd4096;
                default: v = 14'sd0;
            endcase
        endcase
        return v;
    endfunction

    // Coupling C((a - b) mod q); a and b are below q, so one subtract reduces it.
    function automatic logic signed [13:0] coupling(input int q, input logic [2:0] a,
                                                    input logic [2:0] b);
        logic [4:0] d;
        d = 5'(a) + 5'(q) - 5'(b);
        if (d >= 5'(q))
        begin
            d = d - 5'(q);
        end
        return cos_q12(q, d[3:0]);
    endfunction

endpackage

@@ rtl/metropolis_clock_spin_update_top.sv @@
// Top level of the Metropolis clock-spin update block.
// Depends on mcsu_pkg, mcsu_ctrl, mcsu_datapath and mcsu_ram.
//
// A proposal transaction is taken when start is high and busy is low. Its
// result is registered on the result ports and marked by done for exactly one
// cycle, and the receiver cannot stall it. Each transaction reads the site and
// its four neighbors one after another from a single-port lattice store; a
// proposal that needs no exp evaluation (skipped, out of range, or dE <= 0)
// then goes straight to the result, while one with dE > 0 first passes through
// the two multiplies, the four Horner steps and the threshold shift of the
// shared exp unit. After reset the store is cleared one site per cycle, all
// SIDE*SIDE sites (1024 at the default size), with busy held high;
// inverse_temperature may be written through cfg_write and cfg_data at any
// idle time.
module metropolis_clock_spin_update_top
    import mcsu_pkg::*;
#(
    parameter int SIDE   = 32,
    parameter int STATES = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [9:0]         site_index,
    input  logic [2:0]         proposed_state,
    input  logic [15:0]        uniform_draw,
    input  logic               cfg_write,
    input  logic [14:0]        cfg_data,
    output logic               done,
    output logic               accepted,
    output logic               same_state,
    output logic [2:0]         previous_state,
    output logic signed [16:0] energy_change
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    mcsu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Datapath with the lattice store.
    mcsu_datapath #(
        .SIDE   (SIDE),
        .STATES (STATES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .site_index     (site_index),
        .proposed_state (proposed_state),
        .uniform_draw   (uniform_draw),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .done           (done),
        .accepted       (accepted),
        .same_state     (same_state),
        .previous_state (previous_state),
        .energy_change  (energy_change)
    );

endmodule

@@ rtl/mcsu_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module mcsu_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One address per cycle: a write when enabled, and always a registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mcsu_ctrl.sv @@
// Controller state machine of the spin update block.
// Depends on mcsu_pkg for the state, command and status types.
module mcsu_ctrl
    import mcsu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register; reset begins the lattice clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.ram_sel = RS_SITE;
        cmd.hstep   = HS_STEP0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.map_mod = 1'b1;
                state_next  = ST_RC;
            end
            ST_RC:
            begin
                cmd.map_rc = 1'b1;
                state_next = ST_RD_OLD;
            end
            ST_RD_OLD:
            begin
                cmd.ram_sel = RS_SITE;
                state_next  = ST_RD_N0;
            end
            ST_RD_N0:
            begin
                cmd.ram_sel = RS_UP;
                cmd.cap_old = 1'b1;
                state_next  = ST_RD_N1;
            end
            ST_RD_N1:
            begin
                cmd.ram_sel = RS_DOWN;
                cmd.acc_nb  = 1'b1;
                state_next  = ST_RD_N2;
            end
            ST_RD_N2:
            begin
                cmd.ram_sel = RS_LEFT;
                cmd.acc_nb  = 1'b1;
                state_next  = ST_RD_N3;
            end
            ST_RD_N3:
            begin
                cmd.ram_sel = RS_RIGHT;
                cmd.acc_nb  = 1'b1;
                state_next  = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                cmd.acc_nb = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = status.need_exp ? ST_MUL_P : ST_FINISH;
            end
            ST_MUL_P:
            begin
                cmd.mul_p  = 1'b1;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                cmd.mul_y  = 1'b1;
                state_next = ST_H0;
            end
            ST_H0:
            begin
                cmd.horner = 1'b1;
                cmd.hstep  = HS_STEP0;
                state_next = ST_H1;
            end
            ST_H1:
            begin
                cmd.horner = 1'b1;
                cmd.hstep  = HS_STEP1;
                state_next = ST_H2;
            end
            ST_H2:
            begin
                cmd.horner = 1'b1;
                cmd.hstep  = HS_STEP2;
                state_next = ST_H3;
            end
            ST_H3:
            begin
                cmd.horner = 1'b1;
                cmd.hstep  = HS_STEP3;
                state_next = ST_THR;
            end
            ST_THR:
            begin
                cmd.thr    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.ram_sel = RS_SITE;
                cmd.finish  = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/mcsu_datapath.sv @@
// Datapath of the spin update block: site mapping, lattice store, energy
// accumulation, exp threshold unit and result registers. Depends on mcsu_pkg.
module mcsu_datapath
    import mcsu_pkg::*;
#(
    parameter int SIDE   = 32,
    parameter int STATES = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [9:0]         site_index,
    input  logic [2:0]         proposed_state,
    input  logic [15:0]        uniform_draw,
    input  logic               cfg_write,
    input  logic [14:0]        cfg_data,
    output logic               done,
    output logic               accepted,
    output logic               same_state,
    output logic [2:0]         previous_state,
    output logic signed [16:0] energy_change
);

    localparam int SITES = SIDE * SIDE;
    localparam int AW    = $clog2(SITES);
    localparam int RW    = $clog2(SIDE);
    localparam logic [19:0] RECIP_SITES = 20'((1 << 20) / SITES + 1);
    localparam logic [19:0] RECIP_SIDE  = 20'((1 << 20) / SIDE + 1);

    // Input transaction and configuration registers.
    logic [9:0]         raw_reg;
    logic [2:0]         prop_reg;
    logic [15:0]        u_reg;
    logic [14:0]        beta_reg;
    logic [9:0]         s_reg;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      col_reg;
    logic [2:0]         old_reg;
    logic signed [16:0] de_reg;
    logic signed [16:0] de_next;
    logic [30:0]        p_reg;
    logic [24:0]        y_reg;
    logic [16:0]        t_reg;
    logic [16:0]        thr_reg;
    logic [AW-1:0]      clr_reg;
    logic               done_reg;
    logic               acc_reg;
    logic               same_reg;
    logic [2:0]         prev_reg;
    logic signed [16:0] de_out_reg;

    // Control registers: beta, clearing counter and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg <= BETA_RESET;
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                beta_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            done_reg <= cmd.finish;
        end
    end

    assign status.clear_last = (clr_reg == AW'(SITES - 1));

    // Site reduction by reciprocal multiplication: exact for 10-bit inputs.
    logic [29:0] mod_prod;
    logic [9:0]  mod_q;
    logic [25:0] mod_rem;
    logic [29:0] rc_prod;
    logic [9:0]  rc_q;
    logic [17:0] rc_col;

    assign mod_prod = 30'(raw_reg) * 30'(RECIP_SITES);
    assign mod_q    = mod_prod[29:20];
    assign mod_rem  = 26'(raw_reg) - 26'(mod_q) * 26'(SITES);
    assign rc_prod  = 30'(s_reg) * 30'(RECIP_SIDE);
    assign rc_q     = rc_prod[29:20];
    assign rc_col   = 18'(s_reg) - 18'(rc_q) * 18'(SIDE);

    // Neighbor coordinates with periodic wrap.
    logic [RW-1:0] row_up;
    logic [RW-1:0] row_dn;
    logic [RW-1:0] col_lf;
    logic [RW-1:0] col_rt;
    logic [RW-1:0] sel_row;
    logic [RW-1:0] sel_col;

    assign row_up = (row_reg == '0) ? RW'(SIDE - 1) : row_reg - RW'(1);
    assign row_dn = (row_reg == RW'(SIDE - 1)) ? '0 : row_reg + RW'(1);
    assign col_lf = (col_reg == '0) ? RW'(SIDE - 1) : col_reg - RW'(1);
    assign col_rt = (col_reg == RW'(SIDE - 1)) ? '0 : col_reg + RW'(1);

    always_comb
    begin
        sel_row = row_reg;
        sel_col = col_reg;
        unique case (cmd.ram_sel)
            RS_UP:    sel_row = row_up;
            RS_DOWN:  sel_row = row_dn;
            RS_LEFT:  sel_col = col_lf;
            RS_RIGHT: sel_col = col_rt;
            default:  sel_row = row_reg;
        endcase
    end

    // Lattice store address, write and read.
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [2:0]    ram_wdata;
    logic [2:0]    ram_rdata;
    logic          de_le0;
    logic          valid_prop;
    logic          is_same;
    logic          take;

    assign valid_prop = (4'(prop_reg) < 4'(STATES));
    assign is_same    = (prop_reg == old_reg);
    assign de_le0     = de_reg[16] || (de_reg == '0);
    assign take       = valid_prop && !is_same && (de_le0 || (17'(u_reg) < thr_reg));
    assign status.need_exp = valid_prop && !is_same && !de_le0;

    always_comb
    begin
        if (cmd.clear)
        begin
            ram_addr = clr_reg;
        end
        else
        begin
            ram_addr = AW'(sel_row) * AW'(SIDE) + AW'(sel_col);
        end
    end

    assign ram_we    = cmd.clear || (cmd.finish && take);
    assign ram_wdata = cmd.clear ? 3'd0 : prop_reg;

    mcsu_ram #(
        .WIDTH (3),
        .DEPTH (SITES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Energy change contribution of one neighbor.
    assign de_next = de_reg + 17'(coupling(STATES, old_reg, ram_rdata))
                            - 17'(coupling(STATES, prop_reg, ram_rdata));

    // Horner step of the 2^-r series on a shared multiplier.
    logic [15:0] r_val;
    logic [8:0]  ip_val;
    logic [16:0] h_op;
    logic [16:0] h_k;
    logic [32:0] h_prod;
    logic [47:0] y_full;

    assign r_val  = y_reg[15:0];
    assign ip_val = y_reg[24:16];
    assign y_full = 48'(p_reg) * 48'(LOG2E_Q15) + 48'(1 << 22);

    always_comb
    begin
        unique case (cmd.hstep)
            HS_STEP0:
            begin
                h_op = HORNER_C0;
                h_k  = HORNER_K0;
            end
            HS_STEP1:
            begin
                h_op = t_reg;
                h_k  = HORNER_K1;
            end
            HS_STEP2:
            begin
                h_op = t_reg;
                h_k  = HORNER_K2;
            end
            default:
            begin
                h_op = t_reg;
                h_k  = HORNER_K3;
            end
        endcase
    end

    assign h_prod = 33'(r_val) * 33'(h_op);

    // Working registers of one transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg  <= site_index;
            prop_reg <= proposed_state;
            u_reg    <= uniform_draw;
            de_reg   <= '0;
        end
        if (cmd.map_mod)
        begin
            s_reg <= mod_rem[9:0];
        end
        if (cmd.map_rc)
        begin
            row_reg <= rc_q[RW-1:0];
            col_reg <= rc_col[RW-1:0];
        end
        if (cmd.cap_old)
        begin
            old_reg <= ram_rdata;
        end
        if (cmd.acc_nb)
        begin
            de_reg <= de_next;
        end
        if (cmd.mul_p)
        begin
            p_reg <= 31'(beta_reg) * 31'(de_reg[15:0]);
        end
        if (cmd.mul_y)
        begin
            y_reg <= y_full[47:23];
        end
        if (cmd.horner)
        begin
            t_reg <= h_k - 17'(h_prod[32:16]);
        end
        if (cmd.thr)
        begin
            thr_reg <= (ip_val >= 9'd17) ? 17'd0 : (t_reg >> ip_val[4:0]);
        end
        if (cmd.finish)
        begin
            acc_reg    <= take;
            same_reg   <= valid_prop && is_same;
            prev_reg   <= old_reg;
            de_out_reg <= (valid_prop && !is_same) ? de_reg : 17'sd0;
        end
    end

    assign done           = done_reg;
    assign accepted       = acc_reg;
    assign same_state     = same_reg;
    assign previous_state = prev_reg;
    assign energy_change  = de_out_reg;

endmodule

@@ rtl/mcsu_checker.sv @@
// Port-level checker of the spin update block and its bind statement.
// Depends on metropolis_clock_spin_update_top_macros.svh.
`include "metropolis_clock_spin_update_top_macros.svh"

module mcsu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               accepted,
    input logic               same_state,
    input logic signed [16:0] energy_change
);

    // An accepted transaction makes the block busy.
    `MCSU_ASSERT_NEXT(a_start_busy, start && !busy, busy)

    // A result is shown only once the block has returned to idle.
    `MCSU_ASSERT_NOW(a_done_idle, done, !busy)

    // A skipped proposal is never accepted and reports no energy change.
    `MCSU_ASSERT_NOW(a_same_not_acc, done && same_state, !accepted && (energy_change == 17'sd0))

    // Results are single-cycle strobes, never back to back.
    `MCSU_ASSERT_NEXT(a_done_pulse, done, !done)

endmodule

bind metropolis_clock_spin_update_top mcsu_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .accepted      (accepted),
    .same_state    (same_state),
    .energy_change (energy_change)
);
